// ===== sv/battery_charge_estimator_top_assert.svh =====
// Assertion macros used by the charge estimator RTL.
`ifndef BATTERY_CHARGE_ESTIMATOR_TOP_ASSERT_SVH
`define BATTERY_CHARGE_ESTIMATOR_TOP_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define BCE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked during reset.
`define BCE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/bce_pkg.sv =====
// Types and constants of the battery charge estimator.
package bce_pkg;

  localparam int KNEE_NUM    = 6;
  localparam int KNEE_LAST   = KNEE_NUM - 1;
  localparam int PCT_PER_SEG = 20;
  localparam int IDX_W       = 3;
  localparam int DIV_STEPS   = 23;
  localparam int CNT_W       = 5;

  // 100 percent in Q7.16
  localparam logic [22:0] FULL_Q16 = 23'd6553600;

  localparam logic [15:0] KNEE_RST [KNEE_NUM] = '{
    16'd3300, 16'd3500, 16'd3600, 16'd3700, 16'd3900, 16'd4200
  };
  localparam logic [15:0] POLE_RST   = 16'd62259;
  localparam logic [15:0] THRESH_RST = 16'd3000;

  // register index codes (byte address / 4)
  localparam logic [2:0] REG_KNEE0  = 3'd0;
  localparam logic [2:0] REG_KNEE1  = 3'd1;
  localparam logic [2:0] REG_KNEE2  = 3'd2;
  localparam logic [2:0] REG_KNEE3  = 3'd3;
  localparam logic [2:0] REG_KNEE4  = 3'd4;
  localparam logic [2:0] REG_KNEE5  = 3'd5;
  localparam logic [2:0] REG_POLE   = 3'd6;
  localparam logic [2:0] REG_THRESH = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEG,
    ST_DIV,
    ST_MUL,
    ST_ADD
  } state_t;

endpackage

// ===== sv/battery_charge_estimator_top.sv =====
// Battery charge estimator: voltage to filtered state of charge, serial divider core.
//
// One voltage sample (mV) per input transaction gives one output transaction holding
// the filtered charge in Q7.8 percent and a connected flag. The sample is placed on a
// six-point piecewise linear curve (20 percent per segment); below the first knee it
// reads 0 percent, at or above the last knee 100 percent. Inside a segment the slope
// is found by a restoring divider that retires one quotient bit per cycle for a
// 23-bit quotient, so an interpolated sample passes the segment, divide, multiply and
// add steps before the next can be accepted; samples that clamp, hit a flat segment
// or overflow skip the divider. The raw charge then feeds a one-pole filter with
// pole_weight in Q0.16 (one signed multiply, then a rounding add).
// in_tready is high only while the sequencer is idle. A finished result sits in
// the output register and does not block acceptance of the next sample; the
// sequencer waits at its final step only if that register is still occupied.
// Registers (APB, byte addresses): knee_volt_0..5 at 0x00..0x14, pole_weight at 0x18,
// connect_threshold at 0x1C. Write configuration only while no transaction is in flight.
`include "battery_charge_estimator_top_assert.svh"

module battery_charge_estimator_top
  import bce_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // sample stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // [15:0] voltage_mv
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [14:0] charge_pct, [15] connected
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [15:0] knee_r [KNEE_NUM];
  logic [15:0] pole_r;
  logic [15:0] thresh_r;
  logic [2:0]  cfg_idx;
  logic        cfg_wr;

  assign cfg_idx = cfg_paddr[4:2];
  assign cfg_wr  = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KNEE_NUM; i++) begin
        knee_r[i] <= KNEE_RST[i];
      end
      pole_r   <= POLE_RST;
      thresh_r <= THRESH_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx) inside
        REG_KNEE0, REG_KNEE1, REG_KNEE2, REG_KNEE3, REG_KNEE4, REG_KNEE5: begin
          knee_r[cfg_idx] <= cfg_pwdata[15:0];
        end
        REG_POLE:   pole_r   <= cfg_pwdata[15:0];
        REG_THRESH: thresh_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx) inside
      REG_KNEE0, REG_KNEE1, REG_KNEE2, REG_KNEE3, REG_KNEE4, REG_KNEE5: begin
        cfg_prdata = {16'h0000, knee_r[cfg_idx]};
      end
      REG_POLE:   cfg_prdata = {16'h0000, pole_r};
      REG_THRESH: cfg_prdata = {16'h0000, thresh_r};
      default:    cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  state_t state_r, state_nxt;

  logic [15:0]      v_r;
  logic             conn_r;
  logic [15:0]      d_r, w_r;
  logic [22:0]      start_r, start_nxt;
  logic [15:0]      rem_r, rem_nxt;
  logic [22:0]      lo_r, lo_nxt;
  logic [22:0]      q_r, q_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [22:0]      raw_r, raw_nxt;
  logic signed [41:0] prod_r;
  logic [22:0]      fc_r;
  logic             out_valid_r;
  logic [15:0]      out_data_r;

  logic in_acc, out_free, go_div, div_last;

  assign in_acc   = in_tvalid & in_tready;
  assign out_free = ~out_valid_r | out_tready;
  assign div_last = (cnt_r == CNT_W'(DIV_STEPS - 1));

  // segment search and the cases that bypass the divider
  logic [15:0]    seg_vs, seg_ve, seg_d, seg_w;
  logic [IDX_W-1:0] seg_idx;
  logic [20:0]    seg_d20;
  logic [6:0]     seg_pct;
  logic           seg_below, seg_above, seg_flat, seg_ovf;

  always_comb begin
    seg_vs  = knee_r[0];
    seg_ve  = knee_r[1];
    seg_idx = '0;
    for (int i = 1; i < KNEE_LAST; i++) begin
      if (v_r >= knee_r[i]) begin
        seg_idx = IDX_W'(i);
        seg_vs  = knee_r[i];
        seg_ve  = knee_r[i + 1];
      end
    end
    seg_d     = v_r - seg_vs;
    seg_w     = seg_ve - seg_vs;
    seg_d20   = 21'(seg_d) * 21'(PCT_PER_SEG);
    seg_pct   = 7'(seg_idx) * 7'(PCT_PER_SEG);
    seg_below = (v_r < knee_r[0]);
    seg_above = (v_r >= knee_r[KNEE_LAST]);
    seg_flat  = (seg_ve <= seg_vs);
    // quotient would need more than 23 bits: result saturates anyway
    seg_ovf   = ({2'b00, seg_d20} >= {seg_w, 7'b0000000});
    start_nxt = {seg_pct, 16'h0000};
    go_div    = ~seg_below & ~seg_above & ~seg_flat & ~seg_ovf;
  end

  // one restoring divide step per cycle
  logic [16:0] div_t;
  logic        div_ge;
  logic [23:0] tot_sum;

  always_comb begin
    div_t   = {rem_r, lo_r[22]};
    div_ge  = (div_t >= {1'b0, w_r});
    rem_nxt = div_ge ? 16'(div_t - {1'b0, w_r}) : div_t[15:0];
    lo_nxt  = {lo_r[21:0], 1'b0};
    q_nxt   = {q_r[21:0], div_ge};
    cnt_nxt = cnt_r + 1'b1;
    tot_sum = {1'b0, start_r} + {1'b0, q_nxt};
  end

  always_comb begin
    raw_nxt = raw_r;
    unique case (state_r)
      ST_SEG: begin
        if (seg_below) begin
          raw_nxt = '0;
        end else if (seg_above || seg_ovf) begin
          raw_nxt = FULL_Q16;
        end else if (seg_flat) begin
          raw_nxt = start_nxt;
        end
      end
      ST_DIV: begin
        if (div_last) begin
          raw_nxt = (tot_sum > {1'b0, FULL_Q16}) ? FULL_Q16 : tot_sum[22:0];
        end
      end
      default: ;
    endcase
  end

  // filter: fc*p + raw*(1-p) = fc + (raw - fc)*(1-p), all scaled by 2^16
  logic signed [23:0] flt_diff;
  logic        [16:0] flt_wt;
  logic signed [41:0] prod_nxt;
  logic signed [41:0] flt_acc;
  logic        [22:0] fc_nxt;
  logic        [23:0] rnd_sum;

  always_comb begin
    flt_diff = $signed({1'b0, raw_r}) - $signed({1'b0, fc_r});
    flt_wt   = 17'h10000 - {1'b0, pole_r};
    prod_nxt = flt_diff * $signed({1'b0, flt_wt});
    flt_acc  = $signed({3'b000, fc_r, 16'h0000}) + prod_r + 42'sd32768;
    fc_nxt   = flt_acc[38:16];
    rnd_sum  = {1'b0, fc_nxt} + 24'd128;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_SEG;
      ST_SEG:  state_nxt = go_div ? ST_DIV : ST_MUL;
      ST_DIV:  if (div_last) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_ADD;
      ST_ADD:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_tready  = (state_r == ST_IDLE);
    out_tvalid = out_valid_r;
    out_tdata  = out_data_r;
    cfg_pready = 1'b1;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      fc_r        <= '0;
      cnt_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_SEG) begin
        cnt_r <= '0;
      end else if (state_r == ST_DIV) begin
        cnt_r <= cnt_nxt;
      end
      if (state_r == ST_ADD && out_free) begin
        out_valid_r <= 1'b1;
        fc_r        <= fc_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      v_r    <= in_tdata;
      conn_r <= (in_tdata >= thresh_r);
    end
    if (state_r == ST_SEG) begin
      d_r     <= seg_d;
      w_r     <= seg_w;
      start_r <= start_nxt;
      rem_r   <= 16'(seg_d20 >> 7);
      lo_r    <= {seg_d20[6:0], 16'h0000};
      q_r     <= '0;
    end else if (state_r == ST_DIV) begin
      rem_r <= rem_nxt;
      lo_r  <= lo_nxt;
      q_r   <= q_nxt;
    end
    raw_r <= raw_nxt;
    if (state_r == ST_MUL) begin
      prod_r <= prod_nxt;
    end
    if (state_r == ST_ADD && out_free) begin
      out_data_r <= {conn_r, rnd_sum[22:8]};
    end
  end

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  `BCE_ASSERT_NXT(a_accept_starts, clk, rst_n, in_acc, state_r == ST_SEG, "accepted sample did not start the sequencer")
  `BCE_ASSERT_IMP(a_div_count, clk, rst_n, state_r == ST_DIV, cnt_r < CNT_W'(DIV_STEPS), "divider ran past its step count")
  `BCE_ASSERT_IMP(a_filter_range, clk, rst_n, 1'b1, fc_r <= FULL_Q16, "filter state above 100 percent")
  `BCE_ASSERT_IMP(a_raw_range, clk, rst_n, state_r == ST_MUL, raw_r <= FULL_Q16, "raw charge above 100 percent")
  `BCE_ASSERT_IMP(a_div_operands, clk, rst_n, state_r == ST_DIV, rem_r < w_r && d_r != 16'h0000 || rem_r < w_r, "partial remainder not below divisor")

endmodule
